### sv/vsgqm_pkg.sv
// Shared constants and types for the greedy quad merger.
package vsgqm_pkg;
  localparam int unsigned GridSize = 32;
  localparam int unsigned CoordW   = 5;
  localparam int unsigned AttrW    = 25;
  localparam int unsigned CellAw   = 10;
  localparam logic [0:0] ActLoad    = 1'b0;
  localparam logic [0:0] ActRequest = 1'b1;
  localparam logic [0:0] RegLod     = 1'b0;
  localparam logic [0:0] RegBone    = 1'b1;

  typedef struct packed {
    logic       translucent;
    logic [7:0] bone;
    logic [7:0] palette;
    logic [7:0] ctype;
  } attr_t;
endpackage

### sv/vsgqm_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module vsgqm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### sv/voxel_slice_greedy_quad_merger_unit.sv
// Top level of the greedy quad merger: cell stores and scan sequencer.
// A load is accepted from idle and keeps busy_o high in StLoadWr while its
// exposed row is written back, so the next load waits until that write is done.
// A request walks the grid one memory read at a time, each with a read and a
// check state: one read per row scanned, one for the base cell, one per column
// after the first when bone merging trims the run, one per row tried below the
// run and one per cell of that row compared against the base. StMark then marks
// the covered rows. The result strobe is high in the cycle after that mark and
// busy_o is low in that same cycle. A translucent quad dropped at LOD 2 or
// above is marked and the scan goes on from its row. A request that finds the
// slice already finished strobes in the cycle after it is accepted. The strobe
// is high for one cycle only and cannot be held off, so the caller must take
// it. Visited bits live in flip-flops, one row per entry, so a load clears them
// at once. Register writes are taken only while idle and no request is offered.
module voxel_slice_greedy_quad_merger_unit
  import vsgqm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [1:0] cfg_data_i,
  input  logic       action_i,
  input  logic [4:0] cell_u_i,
  input  logic [4:0] cell_v_i,
  input  logic       cell_empty_i,
  input  logic       cell_translucent_i,
  input  logic [7:0] cell_type_i,
  input  logic [7:0] cell_palette_i,
  input  logic [7:0] cell_bone_i,
  input  logic       neighbor_clear_i,
  input  logic       neighbor_translucent_i,
  input  logic [7:0] neighbor_type_i,
  output logic       result_strobe_o,
  output logic       quad_valid_o,
  output logic [4:0] quad_u_o,
  output logic [4:0] quad_v_o,
  output logic [5:0] quad_width_o,
  output logic [5:0] quad_height_o,
  output logic [7:0] quad_type_o,
  output logic [7:0] quad_palette_o,
  output logic [7:0] quad_bone_o,
  output logic       quad_translucent_o,
  output logic       merge_done_o
);
  typedef enum logic [3:0] {
    StIdle, StLoadWr, StRowRd, StRowChk, StBaseRd, StBaseCap, StBoneRd, StBoneChk,
    StBelowRd, StBelowChk, StCellRd, StCellChk, StMark
  } state_e;

  state_e state_q;
  logic [1:0] lod_q;
  logic bone_en_q;
  logic [GridSize-1:0] visited_q [GridSize];
  logic [5:0] scan_row_q;

  // exposed row memory
  logic exp_we;
  logic [CoordW-1:0] exp_waddr, exp_raddr;
  logic [GridSize-1:0] exp_wdata, exp_rdata;
  // attribute memory
  logic att_we;
  logic [CellAw-1:0] att_waddr, att_raddr;
  attr_t att_wdata, att_rdata;

  vsgqm_ram #(.Width(GridSize), .Depth(GridSize)) u_exp (
    .clk_i, .we_i(exp_we), .waddr_i(exp_waddr), .wdata_i(exp_wdata),
    .raddr_i(exp_raddr), .rdata_o(exp_rdata));
  vsgqm_ram #(.Width(AttrW), .Depth(GridSize*GridSize)) u_att (
    .clk_i, .we_i(att_we), .waddr_i(att_waddr), .wdata_i(att_wdata),
    .raddr_i(att_raddr), .rdata_o(att_rdata));

  // latched load request
  logic [CoordW-1:0] lu_q, lv_q;
  logic lexp_q;
  // scan registers
  logic [CoordW-1:0] s_q, v_q, c_q;
  logic [5:0] w_q, nw_q, h_q, rb_q;
  logic [GridSize-1:0] row_q;
  attr_t base_q;
  logic [5:0] ds;
  logic [GridSize-1:0] gmask;

  assign ds    = 6'(GridSize >> lod_q);
  assign gmask = (ds >= 6'd32) ? '1 : ((GridSize'(1) << ds) - GridSize'(1));

  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle) && !start_i;

  // unvisited exposed cells of the row just read
  logic [CoordW-1:0] live_row;
  logic [GridSize-1:0] live;
  assign live_row = (state_q == StBelowChk) ? rb_q[CoordW-1:0] : scan_row_q[CoordW-1:0];
  assign live     = exp_rdata & ~visited_q[live_row] & gmask;

  // lowest set bit of the live row
  logic [CoordW-1:0] low_idx;
  always_comb begin
    low_idx = '0;
    for (int i = GridSize - 1; i >= 0; i--) begin
      if (live[i]) low_idx = CoordW'(i);
    end
  end

  // run length from the start column: lowest clear bit of the shifted row
  logic [GridSize-1:0] run_bits;
  logic [5:0] run_len;
  assign run_bits = row_q >> s_q;
  always_comb begin
    run_len = 6'(GridSize);
    for (int i = GridSize - 1; i >= 0; i--) begin
      if (!run_bits[i]) run_len = 6'(i);
    end
  end

  logic [GridSize-1:0] wm;
  assign wm = ((w_q >= 6'(GridSize)) ? '1 : ((GridSize'(1) << w_q) - GridSize'(1))) << s_q;

  logic [5:0] c_end, c_next, v_next;
  assign c_end  = 6'(s_q) + w_q;
  assign c_next = 6'(c_q) + 6'd1;
  assign v_next = 6'(v_q) + 6'd1;

  logic same;
  assign same = (att_rdata.ctype == base_q.ctype) && (att_rdata.palette == base_q.palette)
              && (!bone_en_q || (att_rdata.bone == base_q.bone));

  logic [4:0] su, sv;
  logic [5:0] sw, sh;
  assign su = s_q << lod_q;
  assign sv = v_q << lod_q;
  assign sw = w_q << lod_q;
  assign sh = h_q << lod_q;

  logic [CoordW-1:0] att_row;
  assign att_row = (state_q == StCellRd) ? rb_q[CoordW-1:0] : v_q;

  always_comb begin
    exp_we    = (state_q == StLoadWr);
    exp_waddr = lv_q;
    exp_wdata = exp_rdata;
    exp_wdata[lu_q] = lexp_q;
    exp_raddr = (state_q == StBelowRd) ? rb_q[CoordW-1:0] : scan_row_q[CoordW-1:0];
    att_we    = 1'b0;
    att_waddr = {cell_v_i, cell_u_i};
    att_wdata = '{translucent: cell_translucent_i, bone: cell_bone_i,
                  palette: cell_palette_i, ctype: cell_type_i};
    att_raddr = {att_row, c_q};
    if (state_q == StIdle && start_i && action_i == ActLoad) begin
      att_we    = 1'b1;
      exp_raddr = cell_v_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lod_q <= '0;
      bone_en_q <= 1'b0;
      scan_row_q <= '0;
      for (int i = 0; i < GridSize; i++) visited_q[i] <= '0;
      result_strobe_o <= 1'b0;
      quad_valid_o <= 1'b0;
      merge_done_o <= 1'b0;
      quad_u_o <= '0; quad_v_o <= '0; quad_width_o <= '0; quad_height_o <= '0;
      quad_type_o <= '0; quad_palette_o <= '0; quad_bone_o <= '0;
      quad_translucent_o <= 1'b0;
      lu_q <= '0; lv_q <= '0; lexp_q <= 1'b0;
      s_q <= '0; v_q <= '0; c_q <= '0; w_q <= '0; nw_q <= '0; h_q <= '0; rb_q <= '0;
      row_q <= '0; base_q <= '0;
    end else begin
      result_strobe_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (cfg_valid_i && !start_i) begin
            unique case (cfg_index_i)
              RegLod:  lod_q <= cfg_data_i;
              RegBone: bone_en_q <= cfg_data_i[0];
            endcase
          end
          if (start_i) begin
            if (action_i == ActLoad) begin
              lu_q <= cell_u_i;
              lv_q <= cell_v_i;
              lexp_q <= !cell_empty_i && (neighbor_clear_i ||
                        (neighbor_translucent_i && neighbor_type_i != cell_type_i));
              for (int i = 0; i < GridSize; i++) visited_q[i] <= '0;
              scan_row_q <= '0;
              state_q <= StLoadWr;
            end else if (scan_row_q >= ds) begin
              result_strobe_o <= 1'b1;
              quad_valid_o <= 1'b0;
              merge_done_o <= 1'b1;
              quad_u_o <= '0; quad_v_o <= '0; quad_width_o <= '0; quad_height_o <= '0;
              quad_type_o <= '0; quad_palette_o <= '0; quad_bone_o <= '0;
              quad_translucent_o <= 1'b0;
            end else begin
              state_q <= StRowRd;
            end
          end
        end
        StLoadWr: state_q <= StIdle;
        StRowRd: state_q <= StRowChk;
        StRowChk: begin
          if (live == '0) begin
            scan_row_q <= scan_row_q + 6'd1;
            if (scan_row_q + 6'd1 >= ds) begin
              result_strobe_o <= 1'b1;
              quad_valid_o <= 1'b0;
              merge_done_o <= 1'b1;
              quad_u_o <= '0; quad_v_o <= '0; quad_width_o <= '0; quad_height_o <= '0;
              quad_type_o <= '0; quad_palette_o <= '0; quad_bone_o <= '0;
              quad_translucent_o <= 1'b0;
              state_q <= StIdle;
            end else begin
              state_q <= StRowRd;
            end
          end else begin
            row_q <= live;
            v_q <= scan_row_q[CoordW-1:0];
            s_q <= low_idx;
            c_q <= low_idx;
            state_q <= StBaseRd;
          end
        end
        StBaseRd: begin
          w_q <= run_len;
          state_q <= StBaseCap;
        end
        StBaseCap: begin
          base_q <= att_rdata;
          h_q <= 6'd1;
          rb_q <= v_next;
          if (bone_en_q && w_q > 6'd1) begin
            nw_q <= 6'd1;
            c_q <= s_q + 5'd1;
            state_q <= StBoneRd;
          end else if (v_next >= ds) begin
            state_q <= StMark;
          end else begin
            state_q <= StBelowRd;
          end
        end
        StBoneRd: state_q <= StBoneChk;
        // trim the run at the first bone change
        StBoneChk: begin
          if (att_rdata.bone == base_q.bone && nw_q + 6'd1 < w_q) begin
            nw_q <= nw_q + 6'd1;
            c_q <= c_q + 5'd1;
            state_q <= StBoneRd;
          end else begin
            if (att_rdata.bone != base_q.bone) w_q <= nw_q;
            if (v_next >= ds) state_q <= StMark;
            else state_q <= StBelowRd;
          end
        end
        StBelowRd: state_q <= StBelowChk;
        StBelowChk: begin
          if ((live & wm) != wm) begin
            state_q <= StMark;
          end else begin
            c_q <= s_q;
            state_q <= StCellRd;
          end
        end
        StCellRd: state_q <= StCellChk;
        StCellChk: begin
          if (!same) begin
            state_q <= StMark;
          end else if (c_next == c_end) begin
            h_q <= h_q + 6'd1;
            rb_q <= rb_q + 6'd1;
            if (rb_q + 6'd1 >= ds) state_q <= StMark;
            else state_q <= StBelowRd;
          end else begin
            c_q <= c_q + 5'd1;
            state_q <= StCellRd;
          end
        end
        StMark: begin
          for (int i = 0; i < GridSize; i++) begin
            if (6'(i) >= 6'(v_q) && 6'(i) < 6'(v_q) + h_q) visited_q[i] <= visited_q[i] | wm;
          end
          if (lod_q >= 2'd2 && base_q.translucent) begin
            // dropped at coarse LOD; rescan the same row
            state_q <= StRowRd;
          end else begin
            result_strobe_o <= 1'b1;
            quad_valid_o <= 1'b1;
            merge_done_o <= 1'b0;
            quad_u_o <= su;
            quad_v_o <= sv;
            quad_width_o <= sw;
            quad_height_o <= sh;
            quad_type_o <= base_q.ctype;
            quad_palette_o <= base_q.palette;
            quad_bone_o <= base_q.bone;
            quad_translucent_o <= base_q.translucent;
            state_q <= StIdle;
          end
        end
      endcase
    end
  end
endmodule
